// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of the search block.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a stalled transfer keeps its valid and payload in the next cycle.
`define ASSERT_HOLD(label, vld, rdy, pay, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(pay))) else $error(msg);

`endif

// ===== hdl/bsfm_pkg.sv =====
// Package of the byte substring search block: sizes, needle type, register codes.
// Used by the cell, chain and top-level RTL files of the block; depends on nothing.
package bsfm_pkg;

    localparam int MAX_NEEDLE   = 16;
    localparam longint MAX_HAYSTACK = 65536;
    localparam int WIN_DEPTH    = MAX_NEEDLE - 1;
    localparam int NLEN_W       = $clog2(MAX_NEEDLE + 1);
    localparam int LEN_W        = 5;
    localparam int CNT_W        = $clog2(MAX_HAYSTACK + 2);
    localparam int POS_W        = 16;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        CFG_NEEDLE_LEN = 2'd0,
        CFG_NEEDLE_LO  = 2'd1,
        CFG_NEEDLE_HI  = 2'd2
    } cfg_idx_t;

    // Needle as seen by the compare chain: clamped length and the sixteen bytes.
    typedef struct packed {
        logic [NLEN_W-1:0] nlen;
        logic [63:0]       lo;
        logic [63:0]       hi;
    } needle_t;

    // Needle byte k; bytes past the sixteenth read as zero.
    function automatic byte_t needle_at(needle_t nd, logic [NLEN_W-1:0] k);
        byte_t res;
        res = 8'h00;
        if (int'(k) < 8)
            res = nd.lo[{k[2:0], 3'b000} +: 8];
        else if (int'(k) < 16)
            res = nd.hi[{k[2:0], 3'b000} +: 8];
        return res;
    endfunction

endpackage

// ===== hdl/bsfm_cell.sv =====
// One cell of the window chain: holds one history byte and compares it.
// Depends on bsfm_pkg.
module bsfm_cell
    import bsfm_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  byte_t byte_in,
    input  byte_t needle_byte,
    input  logic  active,
    input  logic  match_in,
    output byte_t byte_out,
    output logic  match_out
);

    byte_t byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out  = byte_reg;
    assign match_out = match_in & (~active | (byte_reg == needle_byte));

endmodule

// ===== hdl/bsfm_chain.sv =====
// Row of window cells with the compare of the incoming byte at its head.
// Depends on bsfm_pkg and bsfm_cell.
module bsfm_chain
    import bsfm_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  byte_t   byte_in,
    input  needle_t needle,
    output logic    match
);

    byte_t byte_w  [WIN_DEPTH];
    logic  match_w [WIN_DEPTH+1];

    // The newest byte lines up with the last needle byte in use.
    assign byte_w[0]  = byte_in;
    assign match_w[0] = (needle.nlen == '0) |
                        (byte_in == needle_at(needle, needle.nlen - NLEN_W'(1)));

    for (genvar i = 0; i < WIN_DEPTH; i++)
    begin : g_cell
        logic              act;
        logic [NLEN_W-1:0] k;

        // Cell i holds the byte i+1 places back; it meets needle byte nlen-2-i.
        assign act = (NLEN_W'(i + 1) < needle.nlen);
        assign k   = needle.nlen - NLEN_W'(i + 2);

        if (i < WIN_DEPTH - 1)
        begin : g_mid
            bsfm_cell u_cell (
                .clk         (clk),
                .shift       (shift),
                .byte_in     (byte_w[i]),
                .needle_byte (needle_at(needle, k)),
                .active      (act),
                .match_in    (match_w[i]),
                .byte_out    (byte_w[i+1]),
                .match_out   (match_w[i+1])
            );
        end
        else
        begin : g_tail
            bsfm_cell u_cell (
                .clk         (clk),
                .shift       (shift),
                .byte_in     (byte_w[i]),
                .needle_byte (needle_at(needle, k)),
                .active      (act),
                .match_in    (match_w[i]),
                .byte_out    (),
                .match_out   (match_w[i+1])
            );
        end
    end

    assign match = match_w[WIN_DEPTH];

endmodule

// ===== hdl/byte_substring_first_match_unit.sv =====
// Top level of the streamed first-match byte substring search.
// Depends on bsfm_pkg and bsfm_chain (which uses bsfm_cell).
//
// Haystack bytes enter on the s_ stream, one transfer per byte: s_tdata holds
// the byte, s_tuser marks the first byte of a haystack and s_tlast the last.
// Each haystack gives at most one result on the m_ stream: found with the start
// offset of the first occurrence of the needle, or, on the last byte when
// nothing matched, a not-found result. Bytes after a match give nothing further.
// The needle is set through the cfg_ write channel (index 0 length, 1 bytes 0
// to 7, 2 bytes 8 to 15) by the user only while no haystack is in flight; the
// block does not enforce this. cfg_ready is always high. Offsets beyond 65535
// and haystacks over 65536 bytes raise the saturation flag. A result appears on
// m_ in the cycle after the input transfer that causes it. One byte is taken in
// every cycle; the rate is set by the combinational compare across the row of
// fifteen window cells plus the incoming byte. s_tready is high whenever the
// output register is empty or being drained, so a stall on m_tready holds the
// pending result and stops new input only while that result waits.
// Reset clears the needle to empty, clears the byte count and the match flag
// and empties the output register. The next byte starts a new haystack.
module byte_substring_first_match_unit
    import bsfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Haystack input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] first_byte
    input  logic        s_tlast,    // last_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [15:0] match_start, [16] position_saturated, rest 0
    output logic        m_tuser,    // [0] found
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Configuration registers
    logic [LEN_W-1:0] needle_len_reg;
    logic [63:0]      needle_lo_reg;
    logic [63:0]      needle_hi_reg;

    // Haystack state
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             done_reg, done_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic             sat_reg, sat_next;

    needle_t          needle;
    logic             s_fire;
    logic             window_match;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] cnt_new;
    logic [CNT_W-1:0] start_pos;
    logic             searching;
    logic             hit;
    logic             emit;
    logic             over_count;
    logic             over_start;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_len_reg <= '0;
            needle_lo_reg  <= '0;
            needle_hi_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NEEDLE_LEN: needle_len_reg <= cfg_data[LEN_W-1:0];
                CFG_NEEDLE_LO:  needle_lo_reg  <= cfg_data;
                CFG_NEEDLE_HI:  needle_hi_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Lengths above the window size behave as the full window.
    always_comb
    begin
        needle.lo = needle_lo_reg;
        needle.hi = needle_hi_reg;
        if (int'(needle_len_reg) > MAX_NEEDLE)
            needle.nlen = NLEN_W'(MAX_NEEDLE);
        else
            needle.nlen = NLEN_W'(needle_len_reg);
    end

    assign s_tready = ~m_valid_reg | m_tready;
    assign s_fire   = s_tvalid & s_tready;

    bsfm_chain u_chain (
        .clk     (clk),
        .shift   (s_fire),
        .byte_in (s_tdata),
        .needle  (needle),
        .match   (window_match)
    );

    // Byte count after this byte, saturating one past the haystack limit.
    always_comb
    begin
        cnt_base = s_tuser ? '0 : seen_reg;
        if (cnt_base <= CNT_W'(MAX_HAYSTACK))
            cnt_new = cnt_base + CNT_W'(1);
        else
            cnt_new = cnt_base;

        searching  = s_tuser | ~done_reg;
        hit        = (needle.nlen == '0) |
                     ((cnt_new >= CNT_W'(needle.nlen)) & window_match);
        start_pos  = (needle.nlen == '0) ? '0 : (cnt_new - CNT_W'(needle.nlen));
        over_count = (cnt_new > CNT_W'(MAX_HAYSTACK));
        over_start = (64'(start_pos) > 64'((1 << POS_W) - 1));
        emit       = s_fire & searching & (hit | s_tlast);
    end

    // Haystack state: a last byte always ends the haystack.
    always_comb
    begin
        seen_next = seen_reg;
        done_next = done_reg;
        if (s_fire)
        begin
            if (s_tlast)
            begin
                seen_next = '0;
                done_next = 1'b0;
            end
            else
            begin
                seen_next = cnt_new;
                done_next = (~s_tuser & done_reg) | (searching & hit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            done_reg <= done_next;
        end
    end

    // Output register: loaded whenever an emitting transfer is taken.
    always_comb
    begin
        m_valid_next = m_valid_reg & ~m_tready;
        found_next   = found_reg;
        start_next   = start_reg;
        sat_next     = sat_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            found_next   = hit;
            if (hit)
            begin
                sat_next   = over_count | over_start;
                start_next = (over_count | over_start) ? '1 : start_pos[POS_W-1:0];
            end
            else
            begin
                sat_next   = over_count;
                start_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        start_reg <= start_next;
        sat_reg   <= sat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {7'b0, sat_reg, start_reg};

endmodule

// ===== hdl/bsfm_checker.sv =====
// Port-level checks of the byte substring search unit, bound to its top level.
// Depends on assert_macros.svh and byte_substring_first_match_unit.
`include "assert_macros.svh"

module bsfm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser
);

    logic [15:0] offset;
    logic        sat;

    assign offset = m_tdata[15:0];
    assign sat    = m_tdata[16];

    // A not-found result always carries a zero offset.
    `ASSERT_CLK(a_miss_zero, (m_tvalid && !m_tuser) |-> (offset == '0), "miss with offset")

    // A saturated match reports the top offset.
    `ASSERT_CLK(a_sat_top, (m_tvalid && m_tuser && sat) |-> (offset == '1), "sat offset not top")

    // Input is only held back while a result is waiting.
    `ASSERT_CLK(a_ready_free, !m_tvalid |-> s_tready, "input stalled with an empty output")

    // A stalled result keeps its payload.
    `ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, {m_tuser, m_tdata}, "stalled result changed")

endmodule

bind byte_substring_first_match_unit bsfm_checker u_bsfm_checker (.*);

// ===== tb/sv/byte_substring_first_match_unit_test.sv =====
// Testbench for the streamed first-match byte substring search block.
// Depends on bsfm_pkg and on the RTL of byte_substring_first_match_unit only.
// Every expected result comes from a predictor in this file; nothing is read from disk.
`timescale 1ns / 100ps

module byte_substring_first_match_unit_test;

    import bsfm_pkg::*;

    // The watchdog gives up after this many cycles without any transfer. The longest
    // legitimate quiet spell is the receiver's long hold-off (LONG_HOLD) plus a sender
    // gap, so this leaves a wide margin.
    localparam int QUIET_LIMIT    = 3000;
    // Cycles the receiver holds off in the pressure phase.
    localparam int LONG_HOLD      = 300;
    // Cycles allowed after the last expected result before the block is called idle.
    // A result follows its input in the next cycle, so a handful is ample.
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 500;

    // One haystack byte as queued for the sender.
    typedef struct packed {
        byte_t data;
        logic  is_first;
        logic  is_last;
    } hay_byte_t;

    // One search result as carried on the result stream.
    typedef struct packed {
        logic        found;
        logic [15:0] start;
        logic        sat;
    } search_result_t;

    // How the receiver applies back-pressure during a phase.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] first_byte
    logic        s_tlast = 1'b0;    // last_byte

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [15:0] match_start, [16] position_saturated, rest 0
    logic        m_tuser;           // [0] found

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_data = 64'd0;

    byte_substring_first_match_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------

    // Bytes waiting for the sender, filled by the stimulus process.
    hay_byte_t      pending_bytes[$];
    // Results the predictor has worked out and the block has not yet delivered.
    search_result_t expected_results[$];

    // Needle as the predictor sees it: updated on each accepted register write.
    logic [4:0]  cfg_len = 5'd0;
    logic [63:0] cfg_lo  = 64'd0;
    logic [63:0] cfg_hi  = 64'd0;

    // Predictor copy of the haystack state.
    byte_t history [WIN_DEPTH];
    int    seen_count = 0;
    logic  match_done = 1'b0;

    // Needle as the stimulus generator last chose it, used to plant matches.
    int          stim_len = 0;
    logic [63:0] stim_lo  = 64'd0;
    logic [63:0] stim_hi  = 64'd0;

    // Knobs set by the stimulus process and read by the sender and the receiver.
    logic        sender_gappy   = 1'b0;
    ready_mode_t ready_mode     = READY_ALWAYS;
    logic        want_long_hold = 1'b0;

    // Sender and receiver private state.
    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   ready_tick = 0;
    int   long_hold_left = 0;
    logic long_hold_done = 1'b0;
    logic next_ready;
    hay_byte_t next_byte;

    // Run statistics and error count.
    int mismatch_count = 0;
    int bytes_accepted = 0;
    int results_checked = 0;
    int found_count = 0;
    int sat_count = 0;
    int needles_set = 0;
    int random_queued = 0;
    int quiet_cycles = 0;

    search_result_t got_result;
    search_result_t want_result;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Needle byte k from a pair of 64-bit halves; bytes past the sixteenth are zero.
    function automatic byte_t needle_byte(logic [63:0] lo, logic [63:0] hi, int k);
        byte_t b;
        b = 8'h00;
        if (k < 8)
            b = lo[8*k +: 8];
        else if (k < 16)
            b = hi[8*(k-8) +: 8];
        return b;
    endfunction

    function automatic int clamp_len(int len);
        return (len > MAX_NEEDLE) ? MAX_NEEDLE : len;
    endfunction

    function automatic void clear_history();
        for (int k = 0; k < WIN_DEPTH; k++)
            history[k] = 8'h00;
        seen_count = 0;
        match_done = 1'b0;
    endfunction

    // Advances the search by one accepted byte and queues the result it causes, if any.
    // The needle is compared against the incoming byte plus the newest bytes of history,
    // which finds the same first occurrence as a skip-table search would.
    task automatic advance_search(byte_t b, logic is_first, logic is_last);
        int n;
        int start;
        int k;
        logic hit;
        search_result_t r;
        if (is_first)
            clear_history();
        // The count stops one past the largest haystack so that overflow stays visible.
        if (seen_count <= MAX_HAYSTACK)
            seen_count++;
        if (!match_done)
        begin
            n = clamp_len(int'(cfg_len));
            hit = 1'b0;
            if (n == 0)
            begin
                hit = 1'b1;
            end
            else if (seen_count >= n)
            begin
                hit = (needle_byte(cfg_lo, cfg_hi, n - 1) == b);
                for (k = 1; k < n; k++)
                    if (needle_byte(cfg_lo, cfg_hi, n - 1 - k) != history[k-1])
                        hit = 1'b0;
            end
            if (hit)
            begin
                start = (n == 0) ? 0 : seen_count - n;
                r.found = 1'b1;
                r.sat = (seen_count > MAX_HAYSTACK) || (start > 65535);
                r.start = r.sat ? 16'hFFFF : start[15:0];
                expected_results.push_back(r);
                match_done = 1'b1;
            end
            else if (is_last)
            begin
                // A miss reports offset zero even when the count overflowed.
                r.found = 1'b0;
                r.start = 16'd0;
                r.sat = (seen_count > MAX_HAYSTACK);
                expected_results.push_back(r);
            end
        end
        for (k = WIN_DEPTH - 1; k > 0; k--)
            history[k] = history[k-1];
        history[0] = b;
        // The last byte closes the haystack, so the next byte starts afresh.
        if (is_last)
            clear_history();
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples every channel at the rising edge. Results are checked
    // before the byte of the same edge is predicted; that byte's result passes
    // the output register first, so the order keeps expectations in step.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got_result.found = m_tuser;
                got_result.start = m_tdata[15:0];
                got_result.sat = m_tdata[16];
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result found=%0b start=%0d sat=%0b",
                                              got_result.found, got_result.start,
                                              got_result.sat));
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.found !== want_result.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  got_result.found, want_result.found));
                    if (got_result.start !== want_result.start)
                        report_mismatch($sformatf("match_start %0d, expected %0d",
                                                  got_result.start, want_result.start));
                    if (got_result.sat !== want_result.sat)
                        report_mismatch($sformatf("position_saturated %0b, expected %0b",
                                                  got_result.sat, want_result.sat));
                    if (m_tdata[23:17] !== 7'd0)
                        report_mismatch($sformatf("padding bits %b, expected zero",
                                                  m_tdata[23:17]));
                    if (want_result.found)
                        found_count++;
                    if (want_result.sat)
                        sat_count++;
                end
                results_checked++;
            end
            if (s_tvalid && s_tready)
            begin
                advance_search(s_tdata, s_tuser, s_tlast);
                bytes_accepted++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_NEEDLE_LEN: cfg_len = cfg_data[4:0];
                    CFG_NEEDLE_LO:  cfg_lo = cfg_data;
                    CFG_NEEDLE_HI:  cfg_hi = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transfer on any channel counts as progress.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, expected_results.size());
                $display("byte_substring_first_match_unit_test: done, errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: works at the falling edge. A byte stays on the bus until the
    // monitor has seen it taken; then the next one is offered, unless a gap
    // between bursts is being served.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                next_byte = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_byte.data;
                s_tuser  <= next_byte.is_first;
                s_tlast  <= next_byte.is_last;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else if (sender_gappy)
                begin
                    burst_left = $urandom_range(0, 11);
                    gap_left = $urandom_range(1, 6);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus one long hold-off on request,
    // counted here so that the sender keeps offering bytes meanwhile.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        ready_tick++;
        if (want_long_hold && !long_hold_done)
        begin
            long_hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (long_hold_left > 0)
        begin
            long_hold_left--;
            next_ready = 1'b0;
        end
        else
        begin
            case (ready_mode)
                READY_RANDOM:  next_ready = ($urandom_range(0, 2) != 0);
                READY_PATTERN: next_ready = ((ready_tick % 7) < 4);
                default:       next_ready = 1'b1;
            endcase
        end
        m_tready <= next_ready;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_byte(byte_t b, logic is_first, logic is_last);
        hay_byte_t h;
        h.data = b;
        h.is_first = is_first;
        h.is_last = is_last;
        pending_bytes.push_back(h);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until the sender has nothing left and every expected result has
    // arrived, then lets the block settle: bytes after a match give no result,
    // so the last one may still be in the block at that point.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_needle(int len, logic [63:0] lo, logic [63:0] hi);
        write_reg(CFG_NEEDLE_LEN, 64'(len));
        write_reg(CFG_NEEDLE_LO, lo);
        write_reg(CFG_NEEDLE_HI, hi);
        stim_len = len;
        stim_lo = lo;
        stim_hi = hi;
        needles_set++;
    endtask

    // Random needle: mostly short, sometimes empty, full or over-long, and a
    // third of the time drawn from two letters so that overlapping near-matches
    // and repeated prefixes are common.
    task automatic pick_needle();
        int len;
        int k;
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = 1;
            2:       len = MAX_NEEDLE;
            3:       len = $urandom_range(MAX_NEEDLE + 1, 31);
            default: len = $urandom_range(2, 8);
        endcase
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0)
        begin
            for (k = 0; k < 8; k++)
            begin
                lo[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
                hi[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
            end
        end
        set_needle(len, lo, hi);
    endtask

    // One haystack of random content. Bytes lean towards the needle's own
    // bytes, and often a whole copy of the needle is planted somewhere.
    task automatic queue_haystack(int len, logic mark_first, logic mark_last);
        int n;
        int plant;
        int i;
        byte_t b;
        n = clamp_len(stim_len);
        plant = -1;
        if (n > 0 && len >= n && $urandom_range(0, 2) != 0)
            plant = $urandom_range(0, len - n);
        for (i = 0; i < len; i++)
        begin
            if (plant >= 0 && i >= plant && i < plant + n)
                b = needle_byte(stim_lo, stim_hi, i - plant);
            else if (n > 0 && $urandom_range(0, 1) == 1)
                b = needle_byte(stim_lo, stim_hi, $urandom_range(0, n - 1));
            else
                b = byte_t'($urandom_range(0, 255));
            queue_byte(b, mark_first && i == 0, mark_last && i == len - 1);
        end
    endtask

    // A run of haystacks, mostly well formed. Some lack a first or a last mark,
    // and now and then a stretch of bytes carries marks at random.
    task automatic random_phase(int target);
        int queued;
        int len;
        int i;
        queued = 0;
        while (queued < target)
        begin
            len = $urandom_range(1, clamp_len(stim_len) + 12);
            if ($urandom_range(0, 6) == 0)
            begin
                for (i = 0; i < len; i++)
                    queue_byte(byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                               $urandom_range(0, 7) == 0);
            end
            else
            begin
                queue_haystack(len, $urandom_range(0, 4) != 0, $urandom_range(0, 7) != 0);
            end
            queued += len;
        end
        random_queued += queued;
    endtask

    initial
    begin
        int k;
        clear_history();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. After reset the needle is empty: the first byte of a
        // haystack matches at offset zero and later bytes only pass through.
        // A last byte then clears the haystack, so the next byte starts a new
        // one even without a first mark.
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h41, 1'b0, 1'b1);
        wait_idle();

        // Three-byte needle "abc". A haystack shorter than the needle ends
        // without a match; a first mark mid-stream drops the partial match
        // before it; bytes after a match, the last one included, give nothing.
        set_needle(3, 64'h0000_0000_0063_6261, 64'd0);
        queue_byte(8'h61, 1'b1, 1'b0);
        queue_byte(8'h62, 1'b0, 1'b1);
        queue_byte(8'h78, 1'b1, 1'b0);
        queue_byte(8'h61, 1'b0, 1'b0);
        queue_byte(8'h62, 1'b0, 1'b0);
        queue_byte(8'h63, 1'b0, 1'b1);
        queue_byte(8'h61, 1'b1, 1'b0);
        queue_byte(8'h62, 1'b0, 1'b0);
        queue_byte(8'h63, 1'b1, 1'b0);
        queue_byte(8'h61, 1'b0, 1'b0);
        queue_byte(8'h62, 1'b0, 1'b0);
        queue_byte(8'h63, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b1);
        wait_idle();

        // A length above the needle capacity acts as the full sixteen bytes;
        // the needle spans both byte registers and holds 00 and FF.
        set_needle(31, 64'h8877_6655_4433_2211, 64'h00FF_EEDD_CCBB_AA99);
        for (k = 0; k < MAX_NEEDLE; k++)
            queue_byte(needle_byte(stim_lo, stim_hi, k), k == 0, k == MAX_NEEDLE - 1);
        wait_idle();

        // Byte registers at all ones.
        set_needle(2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        wait_idle();

        // Pressure: a one-byte needle makes results frequent, the receiver
        // holds off for a long stretch and the sender keeps offering bytes, so
        // the block fills up and has to stall its input.
        sender_gappy = 1'b1;
        ready_mode = READY_ALWAYS;
        set_needle(1, {$urandom, $urandom}, {$urandom, $urandom});
        want_long_hold = 1'b1;
        random_phase(60);
        wait_idle();

        // Random part: new needle, sender and receiver behaviour per phase, and
        // the sender drains completely before each change of needle.
        while (random_queued < RANDOM_ITEMS)
        begin
            pick_needle();
            sender_gappy = ($urandom_range(0, 3) != 0);
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            random_phase(60);
            wait_idle();
        end

        $display("Ran %0d haystack bytes through %0d needle settings and checked %0d results",
                 bytes_accepted, needles_set, results_checked);
        $display("(%0d matches, %0d misses, %0d with the position flag), %0d mismatches",
                 found_count, results_checked - found_count, sat_count, mismatch_count);
        if (mismatch_count == 0)
            $display("byte_substring_first_match_unit_test: done, clean");
        else
            $display("byte_substring_first_match_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bsfm_pkg.sv
hdl/bsfm_cell.sv
hdl/bsfm_chain.sv
hdl/byte_substring_first_match_unit.sv
hdl/bsfm_checker.sv
tb/sv/byte_substring_first_match_unit_test.sv
